// File: rtl/fixed_point_to_decimal_ascii_core_defines.svh
// Assertion macros used by the converter's serializer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIXED_POINT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define FIXED_POINT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTOA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("ftoa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("ftoa assertion failed");

`endif

// File: rtl/ftoa_pkg.sv
// Types and constants of the fixed-point to decimal ASCII converter.
// Depends on nothing; used by every module of the block.
package ftoa_pkg;

  localparam int NUM_STAGES  = 10;
  localparam int INT_DIGITS  = 10;
  localparam int TEXT_DIGITS = 20;
  localparam int BCD_W       = 40;

  localparam logic [33:0] INT_LIMIT = 34'd9999999999;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic       neg;
    logic       clamp;
    logic [3:0] prec;
    logic       rnd;
  } ftoa_ctrl_t;

endpackage

// File: rtl/ftoa_dig.sv
// One digit stage: four double-dabble steps of the integer part and one
// fraction digit. Depends on ftoa_pkg.
module ftoa_dig #(
  parameter int FRACTION_BITS = 32,
  parameter int STAGE         = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ftoa_pkg::ftoa_ctrl_t       in_ctrl_i,
  input  logic [ftoa_pkg::BCD_W-1:0] in_bcd_i,
  input  logic [ftoa_pkg::BCD_W-1:0] in_ip_i,
  input  logic [FRACTION_BITS-1:0]   in_rem_i,
  input  logic [ftoa_pkg::BCD_W-1:0] in_frac_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ftoa_pkg::ftoa_ctrl_t       out_ctrl_o,
  output logic [ftoa_pkg::BCD_W-1:0] out_bcd_o,
  output logic [ftoa_pkg::BCD_W-1:0] out_ip_o,
  output logic [FRACTION_BITS-1:0]   out_rem_o,
  output logic [ftoa_pkg::BCD_W-1:0] out_frac_o
);
  import ftoa_pkg::*;

  localparam logic [3:0] STAGE_IDX = 4'(STAGE);

  logic                     valid_q;
  ftoa_ctrl_t               ctrl_d, ctrl_q;
  logic [BCD_W-1:0]         bcd_d, bcd_q, ip_d, ip_q, frac_d, frac_q;
  logic [FRACTION_BITS-1:0] rem_d, rem_q;
  logic [FRACTION_BITS+3:0] prod;

  always_comb begin
    prod = ({4'b0, in_rem_i} << 3) + ({4'b0, in_rem_i} << 1);
    rem_d = prod[FRACTION_BITS-1:0];
    frac_d = in_frac_i;
    frac_d[STAGE*4 +: 4] = prod[FRACTION_BITS+3:FRACTION_BITS];

    // The rounding bit is the first fraction bit left after prec digits.
    ctrl_d = in_ctrl_i;
    if (in_ctrl_i.prec == STAGE_IDX && STAGE_IDX != 4'd0) begin
      ctrl_d.rnd = in_rem_i[FRACTION_BITS-1];
    end

    bcd_d = in_bcd_i;
    ip_d  = in_ip_i;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < INT_DIGITS; k++) begin
        if (bcd_d[k*4 +: 4] >= 4'd5) begin
          bcd_d[k*4 +: 4] = bcd_d[k*4 +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], ip_d[BCD_W-1]};
      ip_d  = {ip_d[BCD_W-2:0], 1'b0};
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctrl_q <= ctrl_d;
      bcd_q  <= bcd_d;
      ip_q   <= ip_d;
      rem_q  <= rem_d;
      frac_q <= frac_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_bcd_o   = bcd_q;
  assign out_ip_o    = ip_q;
  assign out_rem_o   = rem_q;
  assign out_frac_o  = frac_q;

endmodule

// File: rtl/ftoa_ser.sv
// Character serializer: sign, integer digits without leading zeros, point
// and fraction digits, one per cycle when ready. Uses ftoa_pkg, defines.
module ftoa_ser (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic                                      in_neg_i,
  input  logic [3:0]                                in_prec_i,
  input  ftoa_pkg::digit_t [ftoa_pkg::TEXT_DIGITS-1:0] in_dig_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [7:0]                                character_o,
  output logic                                      last_o
);
  import ftoa_pkg::*;
  `include "fixed_point_to_decimal_ascii_core_defines.svh"

  localparam logic [1:0] PH_SIGN  = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_DOT   = 2'd2;

  localparam logic [4:0] POS_UNITS = 5'(INT_DIGITS - 1);
  localparam logic [4:0] POS_FRAC  = 5'(INT_DIGITS);

  logic                         busy_d, busy_q;
  logic [1:0]                   phase_d, phase_q;
  logic [4:0]                   pos_d, pos_q;
  logic [3:0]                   prec_q;
  digit_t [TEXT_DIGITS-1:0]     dig_q;
  logic [4:0]                   last_pos, lead;
  logic                         is_last, load;

  assign last_pos = POS_UNITS + {1'b0, prec_q};
  assign is_last  = phase_q == PH_DIGIT && pos_q == last_pos;
  assign in_ready_o = !busy_q || (out_ready_i && is_last);
  assign load = in_valid_i && in_ready_o;

  // First nonzero integer digit; the units digit always prints.
  always_comb begin
    lead = POS_UNITS;
    for (int k = INT_DIGITS - 2; k >= 0; k--) begin
      if (in_dig_i[k] != 4'd0) begin
        lead = 5'(k);
      end
    end
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    if (load) begin
      busy_d  = 1'b1;
      phase_d = in_neg_i ? PH_SIGN : PH_DIGIT;
      pos_d   = lead;
    end else if (busy_q && out_ready_i) begin
      case (phase_q)
        PH_SIGN: begin
          phase_d = PH_DIGIT;
        end
        PH_DIGIT: begin
          if (is_last) begin
            busy_d = 1'b0;
          end else if (pos_q == POS_UNITS) begin
            phase_d = PH_DOT;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
        PH_DOT: begin
          phase_d = PH_DIGIT;
          pos_d   = POS_FRAC;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_SIGN;
      pos_q   <= 5'd0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prec_q <= in_prec_i;
      dig_q  <= in_dig_i;
    end
  end

  always_comb begin
    case (phase_q)
      PH_SIGN:  character_o = CH_MINUS;
      PH_DOT:   character_o = CH_DOT;
      default:  character_o = CH_ZERO + {4'b0, dig_q[pos_q]};
    endcase
  end

  assign out_valid_o = busy_q;
  assign last_o      = is_last;

  `FTOA_ASSERT_IMPL(a_dot_has_fraction, clk_i, rst_ni,
    busy_q && phase_q == PH_DOT, prec_q != 4'd0 && pos_q == POS_UNITS)
  `FTOA_ASSERT_IMPL(a_pos_in_text, clk_i, rst_ni,
    busy_q && phase_q == PH_DIGIT, pos_q <= last_pos)
  `FTOA_ASSERT_NEXT(a_sign_then_digit, clk_i, rst_ni,
    busy_q && out_ready_i && phase_q == PH_SIGN, busy_q && phase_q == PH_DIGIT)
  `FTOA_ASSERT_NEXT(a_dot_then_fraction, clk_i, rst_ni,
    busy_q && out_ready_i && phase_q == PH_DOT, phase_q == PH_DIGIT && pos_q == POS_FRAC)

endmodule

// File: rtl/fixed_point_to_decimal_ascii_core.sv
// An accepted request passes the magnitude, split, ten digit and rounding
// registers, then the serializer, before its first character. Characters
// leave one per cycle while result_ready_i is high; a value's text has 1 to
// 22 characters; the serializer takes the next value only with its last
// one and sets the sustained rate. Reset is asynchronous, active low, clears
// all valid bits and sets the precision register to 10; no clearing pass.
module fixed_point_to_decimal_ascii_core #(
  parameter int MAX_FRACTION_DIGITS = 10,
  parameter int INTEGER_BITS        = 32,
  parameter int FRACTION_BITS       = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        value_valid_i,
  output logic        value_ready_o,
  input  logic [63:0] value_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);
  import ftoa_pkg::*;

  localparam int         LIM_BITS  = INTEGER_BITS - 1 + FRACTION_BITS;
  localparam logic [3:0] MAX_DIG   = 4'(MAX_FRACTION_DIGITS);
  localparam logic [3:0] LAST_STG  = 4'(NUM_STAGES);
  localparam logic [2:0] ADDR_DIGITS = 3'd0;

  // Configuration register.
  logic [4:0] digits_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DIGITS) ? {{27{digits_q[4]}}, digits_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= 5'd10;
    end else if (psel && penable && pwrite && paddr == ADDR_DIGITS) begin
      digits_q <= pwdata[4:0];
    end
  end

  // Stage 1: sign and saturated magnitude.
  logic        p1_v_q, p1_neg_q, p1_rdy;
  logic [63:0] p1_mag_q, mag;

  always_comb begin
    mag = value_i[63] ? (64'd0 - value_i) : value_i;
    if (mag[63]) begin
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    if (LIM_BITS < 63) begin
      if (|(mag >> LIM_BITS)) begin
        mag = (64'd1 << LIM_BITS) - 64'd1;
      end
    end
  end

  // Stage 2: integer part, fraction and precision.
  logic                     p2_v_q, p2_rdy;
  ftoa_ctrl_t               p2_ctrl_q, p2_ctrl_d;
  logic [BCD_W-1:0]         p2_ip_q;
  logic [FRACTION_BITS-1:0] p2_rem_q;
  logic [63:0]              ip_full;
  logic [33:0]              ip_clip;

  always_comb begin
    ip_full = p1_mag_q >> FRACTION_BITS;
    p2_ctrl_d.neg   = p1_neg_q;
    p2_ctrl_d.clamp = ip_full > {30'd0, INT_LIMIT};
    p2_ctrl_d.rnd   = 1'b0;
    ip_clip = p2_ctrl_d.clamp ? INT_LIMIT : ip_full[33:0];
    if (digits_q[4]) begin
      if (ip_full < 64'd1)           p2_ctrl_d.prec = 4'd6;
      else if (ip_full < 64'd10)     p2_ctrl_d.prec = 4'd5;
      else if (ip_full < 64'd100)    p2_ctrl_d.prec = 4'd4;
      else if (ip_full < 64'd1000)   p2_ctrl_d.prec = 4'd3;
      else if (ip_full < 64'd10000)  p2_ctrl_d.prec = 4'd2;
      else if (ip_full < 64'd100000) p2_ctrl_d.prec = 4'd1;
      else                           p2_ctrl_d.prec = 4'd0;
    end else if (digits_q[3:0] > MAX_DIG) begin
      p2_ctrl_d.prec = MAX_DIG;
    end else begin
      p2_ctrl_d.prec = digits_q[3:0];
    end
  end

  // Digit stages.
  logic [NUM_STAGES:0]      st_v, st_rdy;
  ftoa_ctrl_t               st_ctrl [NUM_STAGES+1];
  logic [BCD_W-1:0]         st_bcd  [NUM_STAGES+1];
  logic [BCD_W-1:0]         st_ip   [NUM_STAGES+1];
  logic [BCD_W-1:0]         st_frac [NUM_STAGES+1];
  logic [FRACTION_BITS-1:0] st_rem  [NUM_STAGES+1];

  assign st_v[0]    = p2_v_q;
  assign st_ctrl[0] = p2_ctrl_q;
  assign st_bcd[0]  = '0;
  assign st_ip[0]   = p2_ip_q;
  assign st_frac[0] = '0;
  assign st_rem[0]  = p2_rem_q;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dig
    ftoa_dig #(
      .FRACTION_BITS(FRACTION_BITS),
      .STAGE        (g)
    ) u_dig (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (st_v[g]),
      .in_ready_o (st_rdy[g]),
      .in_ctrl_i  (st_ctrl[g]),
      .in_bcd_i   (st_bcd[g]),
      .in_ip_i    (st_ip[g]),
      .in_rem_i   (st_rem[g]),
      .in_frac_i  (st_frac[g]),
      .out_valid_o(st_v[g+1]),
      .out_ready_i(st_rdy[g+1]),
      .out_ctrl_o (st_ctrl[g+1]),
      .out_bcd_o  (st_bcd[g+1]),
      .out_ip_o   (st_ip[g+1]),
      .out_rem_o  (st_rem[g+1]),
      .out_frac_o (st_frac[g+1])
    );
  end

  // Rounding stage: add the rounding bit at the last printed digit, carry
  // into the integer digits, and saturate to all nines on overflow or clamp.
  logic                     r_v_q, r_neg_q, ser_rdy;
  logic [3:0]               r_prec_q;
  digit_t [TEXT_DIGITS-1:0] r_dig_q, r_dig_d;
  ftoa_ctrl_t               rc;
  logic                     rnd_eff, carry;
  logic [4:0]               lsb;

  assign rc = st_ctrl[NUM_STAGES];

  always_comb begin
    rnd_eff = !rc.clamp && rc.prec != 4'd0 &&
              ((rc.prec == LAST_STG) ? st_rem[NUM_STAGES][FRACTION_BITS-1] : rc.rnd);
    lsb = 5'(INT_DIGITS - 1) + {1'b0, rc.prec};
    for (int k = 0; k < INT_DIGITS; k++) begin
      r_dig_d[k] = st_bcd[NUM_STAGES][(INT_DIGITS-1-k)*4 +: 4];
      r_dig_d[INT_DIGITS+k] = st_frac[NUM_STAGES][k*4 +: 4];
    end
    carry = 1'b0;
    for (int k = TEXT_DIGITS - 1; k >= 0; k--) begin
      if (5'(k) == lsb) begin
        carry = rnd_eff;
      end
      if (carry) begin
        if (r_dig_d[k] == 4'd9) begin
          r_dig_d[k] = 4'd0;
        end else begin
          r_dig_d[k] = r_dig_d[k] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (rc.clamp || carry) begin
      for (int k = 0; k < TEXT_DIGITS; k++) begin
        r_dig_d[k] = 4'd9;
      end
    end
  end

  assign st_rdy[NUM_STAGES] = !r_v_q || ser_rdy;
  assign p2_rdy = !p2_v_q || st_rdy[0];
  assign p1_rdy = !p1_v_q || p2_rdy;
  assign value_ready_o = p1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      r_v_q  <= 1'b0;
    end else begin
      if (p1_rdy) p1_v_q <= value_valid_i;
      if (p2_rdy) p2_v_q <= p1_v_q;
      if (st_rdy[NUM_STAGES]) r_v_q <= st_v[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && value_valid_i) begin
      p1_neg_q <= value_i[63];
      p1_mag_q <= mag;
    end
    if (p2_rdy && p1_v_q) begin
      p2_ctrl_q <= p2_ctrl_d;
      p2_ip_q   <= {{(BCD_W-34){1'b0}}, ip_clip};
      p2_rem_q  <= p1_mag_q[FRACTION_BITS-1:0];
    end
    if (st_rdy[NUM_STAGES] && st_v[NUM_STAGES]) begin
      r_neg_q  <= rc.neg;
      r_prec_q <= rc.prec;
      r_dig_q  <= r_dig_d;
    end
  end

  ftoa_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (r_v_q),
    .in_ready_o (ser_rdy),
    .in_neg_i   (r_neg_q),
    .in_prec_i  (r_prec_q),
    .in_dig_i   (r_dig_q),
    .out_valid_o(result_valid_o),
    .out_ready_i(result_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule
